/* rtl/lpsr_pkg.sv */
// ----------------------------------------------------------------------------
// lpsr_pkg
// Shared types and codes for the link profile selector with revert.
// ----------------------------------------------------------------------------
package lpsr_pkg;

  // Field widths
  localparam int ProfW   = 2;
  localparam int IndexW  = 8;
  localparam int SecsW   = 16;
  localparam int TimeW   = 48;
  localparam int DlineW  = TimeW + 1;
  localparam int CountW  = 32;
  localparam int ActionW = 3;

  // Milliseconds per second for the deadline
  localparam logic [9:0] MS_PER_SEC = 10'd1000;

  // Request kinds
  localparam logic [1:0] REQ_SET_TX = 2'd0;
  localparam logic [1:0] REQ_SET_RX = 2'd1;
  localparam logic [1:0] REQ_FRAME  = 2'd2;
  localparam logic [1:0] REQ_TICK   = 2'd3;

  // Result actions
  localparam logic [ActionW-1:0] ACT_NOP        = 3'd0;
  localparam logic [ActionW-1:0] ACT_APPLY_TX   = 3'd1;
  localparam logic [ActionW-1:0] ACT_APPLY_RX   = 3'd2;
  localparam logic [ActionW-1:0] ACT_CONFIRM_RX = 3'd3;
  localparam logic [ActionW-1:0] ACT_REVERT     = 3'd4;
  localparam logic [ActionW-1:0] ACT_INVALID    = 3'd5;

  // Registered request, deadline already formed
  typedef struct packed {
    logic [1:0]        req_type;
    logic [IndexW-1:0] profile_index;
    logic              secs_nonzero;
    logic [TimeW-1:0]  now_ms;
    logic [DlineW-1:0] deadline;
  } lpsr_item_t;

  // One result
  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [ProfW-1:0]   tx_profile;
    logic [ProfW-1:0]   rx_profile;
    logic [ProfW-1:0]   pending_profile;
    logic               pending;
    logic [CountW-1:0]  revert_count;
  } lpsr_result_t;

endpackage

/* rtl/lpsr_in_stage.sv */
// ----------------------------------------------------------------------------
// lpsr_in_stage
// Input register: captures a request and forms its revert deadline.
// ----------------------------------------------------------------------------
module lpsr_in_stage (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic                            drain,
  input  logic [1:0]                      req_type,
  input  logic [lpsr_pkg::IndexW-1:0]     profile_index,
  input  logic [lpsr_pkg::SecsW-1:0]      revert_seconds,
  input  logic [lpsr_pkg::TimeW-1:0]      now_ms,
  output lpsr_pkg::lpsr_item_t            item,
  output logic                            item_valid
);
  import lpsr_pkg::*;

  logic [SecsW+9:0]  span_ms;
  logic [DlineW-1:0] deadline;

  // now + seconds * 1000, fits in 49 bits
  assign span_ms  = revert_seconds * MS_PER_SEC;
  assign deadline = {1'b0, now_ms} + DlineW'(span_ms);

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (drain) begin
      item_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (take) begin
      item.req_type      <= req_type;
      item.profile_index <= profile_index;
      item.secs_nonzero  <= (revert_seconds != '0);
      item.now_ms        <= now_ms;
      item.deadline      <= deadline;
    end
  end

endmodule

/* rtl/lpsr_policy.sv */
// ----------------------------------------------------------------------------
// lpsr_policy
// Profile state and the per-request decision.
// ----------------------------------------------------------------------------
module lpsr_policy #(
  parameter int PROFILE_COUNT = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  lpsr_pkg::lpsr_item_t          item,
  input  logic                          boot_wr_en,
  input  logic [lpsr_pkg::ProfW-1:0]    boot_wr_data,
  output lpsr_pkg::lpsr_result_t        result
);
  import lpsr_pkg::*;

  localparam logic [IndexW:0] CountLim = (IndexW + 1)'(PROFILE_COUNT);

  logic [ProfW-1:0]  boot_profile;
  logic [ProfW-1:0]  tx_profile, tx_profile_next;
  logic [ProfW-1:0]  rx_profile, rx_profile_next;
  logic [ProfW-1:0]  pending_profile, pending_profile_next;
  logic              pending, pending_next;
  logic              armed, armed_next;
  logic [DlineW-1:0] deadline, deadline_next;
  logic [CountW-1:0] revert_count, revert_count_next;
  logic [ActionW-1:0] action;
  logic              idx_ok;
  logic [ProfW-1:0]  idx_prof;

  assign idx_ok   = ({1'b0, item.profile_index} < CountLim);
  assign idx_prof = item.profile_index[ProfW-1:0];

  // Decision
  always_comb begin
    tx_profile_next      = tx_profile;
    rx_profile_next      = rx_profile;
    pending_profile_next = pending_profile;
    pending_next         = pending;
    armed_next           = armed;
    deadline_next        = deadline;
    revert_count_next    = revert_count;
    action               = ACT_NOP;
    case (item.req_type)
      REQ_SET_TX: begin
        if (!idx_ok) begin
          action = ACT_INVALID;
        end else begin
          tx_profile_next = idx_prof;
          action          = ACT_APPLY_TX;
        end
      end
      REQ_SET_RX: begin
        if (!idx_ok) begin
          action = ACT_INVALID;
        end else if (idx_prof == rx_profile && !pending) begin
          action = ACT_NOP;
        end else begin
          pending_profile_next = idx_prof;
          pending_next         = 1'b1;
          armed_next           = item.secs_nonzero;
          deadline_next        = item.secs_nonzero ? item.deadline : '0;
          action               = ACT_APPLY_RX;
        end
      end
      REQ_FRAME: begin
        if (pending) begin
          rx_profile_next = pending_profile;
          pending_next    = 1'b0;
          armed_next      = 1'b0;
          deadline_next   = '0;
          action          = ACT_CONFIRM_RX;
        end
      end
      REQ_TICK: begin
        if (pending && armed && ({1'b0, item.now_ms} >= deadline)) begin
          rx_profile_next   = boot_profile;
          pending_next      = 1'b0;
          armed_next        = 1'b0;
          deadline_next     = '0;
          revert_count_next = revert_count + 1'b1;
          action            = ACT_REVERT;
        end
      end
      default: begin
        action = ACT_NOP;
      end
    endcase
  end

  assign result.action          = action;
  assign result.tx_profile      = tx_profile_next;
  assign result.rx_profile      = rx_profile_next;
  assign result.pending_profile = pending_profile_next;
  assign result.pending         = pending_next;
  assign result.revert_count    = revert_count_next;

  // Boot profile register
  always_ff @(posedge clk) begin
    if (rst) begin
      boot_profile <= '0;
    end else if (boot_wr_en) begin
      boot_profile <= boot_wr_data;
    end
  end

  // State update on each processed request
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_profile      <= '0;
      rx_profile      <= '0;
      pending_profile <= '0;
      pending         <= 1'b0;
      armed           <= 1'b0;
      deadline        <= '0;
      revert_count    <= '0;
    end else if (fire) begin
      tx_profile      <= tx_profile_next;
      rx_profile      <= rx_profile_next;
      pending_profile <= pending_profile_next;
      pending         <= pending_next;
      armed           <= armed_next;
      deadline        <= deadline_next;
      revert_count    <= revert_count_next;
    end
  end

endmodule

/* rtl/lpsr_out_stage.sv */
// ----------------------------------------------------------------------------
// lpsr_out_stage
// Result register toward the master side.
// ----------------------------------------------------------------------------
module lpsr_out_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic                      advance,
  input  lpsr_pkg::lpsr_result_t    result,
  output lpsr_pkg::lpsr_result_t    held,
  output logic                      held_valid
);
  import lpsr_pkg::*;

  // Valid flag: refilled or emptied whenever the slot moves
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (advance) begin
      held_valid <= load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

/* rtl/link_profile_select_revert_core.sv */
// ----------------------------------------------------------------------------
// link_profile_select_revert_core
// Radio link profile selector with automatic revert of the receive side.
// ----------------------------------------------------------------------------
// One request per clock is taken, sustained, while the result side accepts, and
// each request gives exactly one result. The request is registered with
// its revert deadline (now + seconds * 1000) already formed; the policy stage
// then checks the index, compares the deadline and updates the profile state in
// one pass, and the result is held in an output register, so a stalled
// result stops new requests only once the input register is full too. Write
// boot_profile only while no request is in flight; it affects later reverts.
// ----------------------------------------------------------------------------
module link_profile_select_revert_core #(
  parameter int PROFILE_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // profile_index[7:0], revert_seconds[23:8], now_ms[71:24]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  // Result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // tx_profile_out[1:0], rx_profile_out[3:2],
                                 // pending_profile_out[5:4], pending_out[6],
                                 // revert_count_out[38:7], zero[39]
  output logic [2:0]  m_tuser,   // action[2:0]
  // Configuration
  input  logic        boot_profile_wr_en,
  input  logic [1:0]  boot_profile_wr_data
);
  import lpsr_pkg::*;

  lpsr_item_t   item;
  logic         item_valid;
  lpsr_result_t result;
  lpsr_result_t held;
  logic         held_valid;
  logic         advance;
  logic         fire;
  logic         take;

  // Flow control
  assign advance  = !held_valid || m_tready;
  assign fire     = item_valid && advance;
  assign s_tready = !item_valid || advance;
  assign take     = s_tvalid && s_tready;

  lpsr_in_stage u_in (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .drain          (fire),
    .req_type       (s_tuser),
    .profile_index  (s_tdata[7:0]),
    .revert_seconds (s_tdata[23:8]),
    .now_ms         (s_tdata[71:24]),
    .item           (item),
    .item_valid     (item_valid)
  );

  lpsr_policy #(
    .PROFILE_COUNT (PROFILE_COUNT)
  ) u_policy (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .item         (item),
    .boot_wr_en   (boot_profile_wr_en),
    .boot_wr_data (boot_profile_wr_data),
    .result       (result)
  );

  lpsr_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .advance    (advance),
    .result     (result),
    .held       (held),
    .held_valid (held_valid)
  );

  // Result packing
  assign m_tvalid = held_valid;
  assign m_tuser  = held.action;
  assign m_tdata  = {1'b0, held.revert_count, held.pending, held.pending_profile,
                     held.rx_profile, held.tx_profile};

endmodule

/* bench/lpsr_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpsr_checker
// Scoreboard for the link profile selector with revert.
// Watches the request, result and boot profile write ports. Keeps its own
// copy of the profile state, works out the result of every accepted request
// and compares each accepted result, field by field, against the oldest one.
// ----------------------------------------------------------------------------
module lpsr_checker #(
  parameter int PROFILE_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,   // profile_index[7:0], revert_seconds[23:8], now_ms[71:24]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // tx[1:0], rx[3:2], pending_profile[5:4], pending[6],
                                 // revert_count[38:7], zero[39]
  input  logic [2:0]  m_tuser,   // action[2:0]
  input  logic        boot_profile_wr_en,
  input  logic [1:0]  boot_profile_wr_data,
  output int          error_count,
  output int          pending_results
);
  import lpsr_pkg::*;

  // Shadow copy of the selector state
  logic [ProfW-1:0]  boot_sh;
  logic [ProfW-1:0]  tx_sh;
  logic [ProfW-1:0]  rx_sh;
  logic [ProfW-1:0]  pend_prof_sh;
  logic              pend_sh;
  logic              armed_sh;
  logic [DlineW-1:0] dline_sh;
  logic [CountW-1:0] reverts_sh;

  // Results still owed by the block, oldest first
  lpsr_result_t link_results_q[$];
  lpsr_result_t oldest_r;

  // Apply one event to the shadow state and return the result it gives
  function automatic lpsr_result_t apply_link_event(input logic [1:0] kind,
                                                    input logic [IndexW-1:0] idx,
                                                    input logic [SecsW-1:0] secs,
                                                    input logic [TimeW-1:0] now);
    lpsr_result_t r;
    logic         in_range;
    in_range = int'(idx) < PROFILE_COUNT;
    r        = '0;
    r.action = ACT_NOP;
    case (kind)
      REQ_SET_TX: begin
        if (!in_range) begin
          r.action = ACT_INVALID;
        end else begin
          tx_sh    = idx[ProfW-1:0];
          r.action = ACT_APPLY_TX;
        end
      end
      REQ_SET_RX: begin
        if (!in_range) begin
          r.action = ACT_INVALID;
        end else if (idx[ProfW-1:0] != rx_sh || pend_sh) begin
          pend_prof_sh = idx[ProfW-1:0];
          pend_sh      = 1'b1;
          armed_sh     = secs != '0;
          // deadline is 49 bits wide, so it never wraps
          dline_sh     = armed_sh ? {1'b0, now} + DlineW'(secs) * DlineW'(MS_PER_SEC) : '0;
          r.action     = ACT_APPLY_RX;
        end
      end
      REQ_FRAME: begin
        if (pend_sh) begin
          rx_sh    = pend_prof_sh;
          pend_sh  = 1'b0;
          armed_sh = 1'b0;
          dline_sh = '0;
          r.action = ACT_CONFIRM_RX;
        end
      end
      default: begin
        if (pend_sh && armed_sh && {1'b0, now} >= dline_sh) begin
          rx_sh      = boot_sh;
          pend_sh    = 1'b0;
          armed_sh   = 1'b0;
          dline_sh   = '0;
          reverts_sh = reverts_sh + 1'b1;
          r.action   = ACT_REVERT;
        end
      end
    endcase
    r.tx_profile      = tx_sh;
    r.rx_profile      = rx_sh;
    r.pending_profile = pend_prof_sh;
    r.pending         = pend_sh;
    r.revert_count    = reverts_sh;
    return r;
  endfunction

  task automatic compare_field(input string name, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Track requests, results and boot profile writes
  always @(posedge clk) begin
    if (rst) begin
      boot_sh      = '0;
      tx_sh        = '0;
      rx_sh        = '0;
      pend_prof_sh = '0;
      pend_sh      = 1'b0;
      armed_sh     = 1'b0;
      dline_sh     = '0;
      reverts_sh   = '0;
      link_results_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (link_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual action %0h data %0h",
                   $time, m_tuser, m_tdata);
          error_count++;
        end else begin
          oldest_r = link_results_q.pop_front();
          compare_field("action", oldest_r.action, m_tuser);
          compare_field("tx_profile", oldest_r.tx_profile, m_tdata[1:0]);
          compare_field("rx_profile", oldest_r.rx_profile, m_tdata[3:2]);
          compare_field("pending_profile", oldest_r.pending_profile, m_tdata[5:4]);
          compare_field("pending", oldest_r.pending, m_tdata[6]);
          compare_field("revert_count", oldest_r.revert_count, m_tdata[38:7]);
        end
      end
      if (s_tvalid && s_tready) begin
        link_results_q.push_back(apply_link_event(s_tuser, s_tdata[7:0], s_tdata[23:8],
                                                  s_tdata[71:24]));
      end
      // boot profile only matters for later reverts
      if (boot_profile_wr_en) begin
        boot_sh = boot_profile_wr_data;
      end
    end
    pending_results = link_results_q.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the link profile selector with revert.
// A directed run covers range limits, every event kind and the corner cases
// of pending, confirm and revert; then phases of random event sequences run
// under several boot profiles, with random gaps and stalls on both channels outside the quiet phases.
// ----------------------------------------------------------------------------
module tb_top;
  import lpsr_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseCount = 8;
  localparam int PhaseReqs  = 240;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;   // profile_index[7:0], revert_seconds[23:8], now_ms[71:24]
  logic [1:0]  s_tuser = '0;   // req_type[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // tx[1:0], rx[3:2], pending_profile[5:4], pending[6],
                               // revert_count[38:7], zero[39]
  logic [2:0]  m_tuser;        // action[2:0]
  logic        boot_profile_wr_en = 1'b0;
  logic [1:0]  boot_profile_wr_data = '0;

  int          errors;
  int          pending_results;
  int          cycles = 0;
  int          ready_hold = 0;
  bit          quiet = 1'b0;

  // Stimulus-side notion of time and of the last deadline armed
  logic [TimeW-1:0]  wall = '0;
  logic [DlineW-1:0] dline_target = '0;
  bit                dline_set = 1'b0;

  always #10 clk = ~clk;

  link_profile_select_revert_core i_dut (
    .clk                  (clk),
    .rst                  (rst),
    .s_tvalid             (s_tvalid),
    .s_tready             (s_tready),
    .s_tdata              (s_tdata),
    .s_tuser              (s_tuser),
    .m_tvalid             (m_tvalid),
    .m_tready             (m_tready),
    .m_tdata              (m_tdata),
    .m_tuser              (m_tuser),
    .boot_profile_wr_en   (boot_profile_wr_en),
    .boot_profile_wr_data (boot_profile_wr_data)
  );

  lpsr_checker i_checker (
    .clk                  (clk),
    .rst                  (rst),
    .s_tvalid             (s_tvalid),
    .s_tready             (s_tready),
    .s_tdata              (s_tdata),
    .s_tuser              (s_tuser),
    .m_tvalid             (m_tvalid),
    .m_tready             (m_tready),
    .m_tdata              (m_tdata),
    .m_tuser              (m_tuser),
    .boot_profile_wr_en   (boot_profile_wr_en),
    .boot_profile_wr_data (boot_profile_wr_data),
    .error_count          (errors),
    .pending_results      (pending_results)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stall before each result
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      ready_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        ready_hold = quiet ? 0 : $urandom_range(0, 6);
      end
      if (ready_hold != 0) begin
        m_tready   <= 1'b0;
        ready_hold = ready_hold - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // One request: optional gap, then hold valid until accepted
  task automatic send_req(input logic [1:0] kind, input logic [IndexW-1:0] idx,
                          input logic [SecsW-1:0] secs, input logic [TimeW-1:0] now);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {now, secs, idx};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop sending and wait until every result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic set_boot(input logic [1:0] value);
    drain_results();
    boot_profile_wr_en   <= 1'b1;
    boot_profile_wr_data <= value;
    @(posedge clk);
    boot_profile_wr_en <= 1'b0;
  endtask

  function automatic logic [TimeW-1:0] rand_time();
    return TimeW'({$urandom(), $urandom()});
  endfunction

  // Mostly valid indexes, with out-of-range ones mixed in
  function automatic logic [IndexW-1:0] rand_index();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return IndexW'($urandom_range(0, 3));
    if (pick < 90) return IndexW'($urandom_range(4, 255));
    if (pick < 95) return 8'd255;
    return 8'd4;
  endfunction

  function automatic logic [SecsW-1:0] rand_secs();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return '0;
    if (pick < 80) return SecsW'($urandom_range(1, 3));
    if (pick < 95) return SecsW'($urandom_range(1, 60));
    return SecsW'($urandom_range(0, 65535));
  endfunction

  // One random event from a mostly well-formed timeline
  task automatic rand_event();
    int               pick;
    logic [SecsW-1:0] secs;
    logic [DlineW-1:0] near;
    pick = $urandom_range(0, 99);
    // occasional jump of the clock anywhere in the 48-bit range
    if ($urandom_range(0, 49) == 0) begin
      wall = rand_time();
    end else begin
      wall = wall + TimeW'($urandom_range(0, 1500));
    end
    if (pick < 15) begin
      send_req(REQ_SET_TX, rand_index(), SecsW'($urandom_range(0, 65535)), rand_time());
    end else if (pick < 45) begin
      secs = rand_secs();
      if (secs != '0) begin
        dline_target = {1'b0, wall} + DlineW'(secs) * DlineW'(MS_PER_SEC);
        dline_set    = 1'b1;
      end
      send_req(REQ_SET_RX, rand_index(), secs, wall);
    end else if (pick < 60) begin
      send_req(REQ_FRAME, IndexW'($urandom_range(0, 255)), SecsW'($urandom_range(0, 65535)),
               rand_time());
    end else begin
      // ticks often land just around the armed deadline
      if (dline_set && $urandom_range(0, 2) == 0) begin
        near = dline_target - 1'b1 + DlineW'($urandom_range(0, 2));
        wall = near[DlineW-1] ? '1 : near[TimeW-1:0];
      end
      send_req(REQ_TICK, IndexW'($urandom_range(0, 255)), SecsW'($urandom_range(0, 65535)),
               wall);
    end
  endtask

  // Main sequence
  initial begin
    int phase;
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: range limits, each kind, pending and revert corners
    send_req(REQ_SET_TX, 8'd0, 16'd0, '0);
    send_req(REQ_SET_TX, 8'd3, 16'hFFFF, '1);
    send_req(REQ_SET_TX, 8'd4, 16'd0, '0);
    send_req(REQ_SET_TX, 8'd255, 16'd0, '0);
    send_req(REQ_SET_RX, 8'd0, 16'd5, 48'd100);          // same profile, nothing pending
    send_req(REQ_SET_RX, 8'd200, 16'd5, 48'd100);        // out of range
    send_req(REQ_FRAME, 8'hFF, 16'hFFFF, '1);            // nothing pending
    send_req(REQ_TICK, 8'd0, 16'd0, '1);                 // unarmed
    send_req(REQ_SET_RX, 8'd2, 16'd0, '0);               // pending, no deadline
    send_req(REQ_TICK, 8'd0, 16'd0, '1);
    send_req(REQ_SET_RX, 8'd1, 16'hFFFF, '1);            // replace, deadline past 48 bits
    send_req(REQ_TICK, 8'd0, 16'd0, '1);
    send_req(REQ_FRAME, 8'd0, 16'd0, '0);
    send_req(REQ_SET_RX, 8'd3, 16'd1, 48'd1000);
    send_req(REQ_TICK, 8'd0, 16'd0, 48'd1999);           // one ms short
    send_req(REQ_TICK, 8'd0, 16'd0, 48'd2000);           // exactly at deadline
    send_req(REQ_SET_RX, 8'd2, 16'd2, 48'd0);
    send_req(REQ_SET_RX, 8'd3, 16'd0, 48'd5);            // replace and disarm
    send_req(REQ_TICK, 8'd0, 16'd0, '1);
    send_req(REQ_FRAME, 8'd0, 16'd0, '0);
    set_boot(2'd3);
    send_req(REQ_SET_RX, 8'd0, 16'd1, 48'hFFFF_FFFF_0000);
    send_req(REQ_TICK, 8'd0, 16'd0, '1);                 // revert to boot profile 3

    // Random phases, boot profile changed between them
    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0:       set_boot(2'd0);
        1:       set_boot(2'd3);
        2:       set_boot(2'd1);
        3:       set_boot(2'd2);
        default: set_boot(2'($urandom_range(0, 3)));
      endcase
      quiet = (phase == 2 || phase == 5);
      for (n = 0; n < PhaseReqs; n++) begin
        if ($urandom_range(0, 199) == 0) begin
          drain_results();
        end
        rand_event();
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
